/* rtl/core/tas_pkg.sv */
package tas_pkg;

  localparam int CHANNELS    = 16;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  // command queue depth, power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_AW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  localparam logic [2:0] MODE_NONE     = 3'd0;
  localparam logic [2:0] MODE_LOOP     = 3'd1;
  localparam logic [2:0] MODE_ONCE     = 3'd2;
  localparam logic [2:0] MODE_PING     = 3'd3;
  localparam logic [2:0] MODE_REV_ONCE = 3'd4;
  localparam logic [2:0] MODE_REV_LOOP = 3'd5;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_LOAD,
    CMD_DROP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [3:0] channel;
    logic [2:0] mode;
    logic [7:0] duration;
    logic [6:0] count;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } back_state_t;

  // magnitude of a signed 8-bit frame, low 7 bits
  function automatic logic [6:0] shown_frame(input logic [7:0] f);
    logic [7:0] mag;
    begin
      mag = f[7] ? (8'd0 - f) : f;
      return mag[6:0];
    end
  endfunction

endpackage

/* rtl/core/tas_front.sv */
module tas_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [23:0]   s_tdata,   // channel[3:0], mode[6:4], frame_duration[14:7],
                                   // frame_count[21:15], zero fill
  input  logic          s_tuser,   // req_type
  output logic          cmd_valid,
  output tas_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import tas_pkg::*;

  cmd_t            queue [QUEUE_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] fill;
  cmd_t            in_cmd;
  logic            push;
  logic            pop;

  always_comb begin
    in_cmd.channel  = s_tdata[3:0];
    in_cmd.mode     = s_tdata[6:4];
    in_cmd.duration = s_tdata[14:7];
    in_cmd.count    = s_tdata[21:15];
    if (s_tuser == REQ_TICK) begin
      in_cmd.kind = CMD_TICK;
    end else if (32'(s_tdata[3:0]) < CHANNELS) begin
      in_cmd.kind = CMD_LOAD;
    end else begin
      in_cmd.kind = CMD_DROP;
    end
  end

  assign s_tready  = (fill != Q_CW'(QUEUE_DEPTH));
  assign cmd_valid = (fill != '0);
  assign cmd       = queue[rd_ptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + Q_CW'(1);
        2'b01:   fill <= fill - Q_CW'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_cmd;
    end
  end

endmodule

/* rtl/core/tas_back.sv */
module tas_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  tas_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [15:0]   m_tdata,   // out_channel[3:0], frame_index[10:4], zero fill
  output logic          m_tlast
);
  import tas_pkg::*;

  logic [2:0] chan_mode     [CHANNELS];
  logic [7:0] chan_duration [CHANNELS];
  logic [6:0] chan_count    [CHANNELS];
  logic [7:0] tick_count    [CHANNELS];
  logic [7:0] frame_signed  [CHANNELS];

  back_state_t      state;
  back_state_t      state_next;
  logic [CH_W-1:0]  idx;
  logic [RES_W-1:0] res_cnt;
  logic             hold_valid;
  logic [3:0]       hold_chan;
  logic [6:0]       hold_frame;

  logic             obuf_valid;
  logic [3:0]       obuf_chan;
  logic [6:0]       obuf_frame;
  logic             obuf_last;
  logic             out_ready;

  logic             push;
  logic [3:0]       push_chan;
  logic [6:0]       push_frame;
  logic             push_last;
  logic             load_we;
  logic             step_we;
  logic             capture;
  logic             last_idx;

  logic [CH_W-1:0]  cidx;
  logic [7:0]       load_frame;

  logic [7:0]       f;
  logic [7:0]       cnt8;
  logic [7:0]       cm1;
  logic [7:0]       tc1;
  logic [7:0]       f_inc;
  logic [7:0]       f_dec;
  logic             hit;
  logic             active;
  logic [7:0]       f_new;
  logic             chg;

  assign out_ready = !obuf_valid || m_tready;
  assign last_idx  = (idx == CH_W'(CHANNELS - 1));
  assign cidx      = CH_W'(cmd.channel);
  assign load_frame = ((cmd.mode == MODE_ONCE) || (cmd.mode == MODE_REV_LOOP)) ?
                      ({1'b0, cmd.count} - 8'd1) : 8'd0;

  // per-channel step
  always_comb begin
    f     = frame_signed[idx];
    cnt8  = {1'b0, chan_count[idx]};
    cm1   = cnt8 - 8'd1;
    tc1   = tick_count[idx] + 8'd1;
    f_inc = f + 8'd1;
    f_dec = f - 8'd1;
    hit   = (tc1 == chan_duration[idx]);
    unique case (chan_mode[idx])
      MODE_LOOP: begin
        active = 1'b1;
        f_new  = (f_inc == cnt8) ? 8'd0 : f_inc;
      end
      MODE_ONCE: begin
        active = (f != cm1);
        f_new  = f_inc;
      end
      MODE_PING: begin
        active = 1'b1;
        f_new  = (f_inc == cnt8) ? (8'd2 - f_inc) : f_inc;
      end
      MODE_REV_ONCE: begin
        active = (f != 8'd0);
        f_new  = f_dec;
      end
      MODE_REV_LOOP: begin
        active = 1'b1;
        f_new  = f_dec[7] ? cm1 : f_dec;
      end
      default: begin
        active = 1'b0;
        f_new  = f;
      end
    endcase
    chg = active && hit;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && out_ready && (cmd.kind == CMD_TICK)) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (out_ready && last_idx) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop    = 1'b0;
    push       = 1'b0;
    push_chan  = hold_chan;
    push_frame = hold_frame;
    push_last  = 1'b0;
    load_we    = 1'b0;
    step_we    = 1'b0;
    capture    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && out_ready) begin
          cmd_pop = 1'b1;
          if (cmd.kind == CMD_LOAD) begin
            load_we    = 1'b1;
            push       = 1'b1;
            push_chan  = cmd.channel;
            push_frame = shown_frame(load_frame);
            push_last  = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (out_ready) begin
          step_we = 1'b1;
          if (chg && (res_cnt < RES_W'(MAX_RESULTS))) begin
            capture = 1'b1;
            push    = hold_valid;
          end
        end
      end
      ST_FIN: begin
        if (out_ready) begin
          push      = hold_valid;
          push_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      res_cnt    <= '0;
      hold_valid <= 1'b0;
      obuf_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (step_we) begin
        idx <= last_idx ? '0 : idx + CH_W'(1);
      end
      if (cmd_pop) begin
        res_cnt <= '0;
      end else if (capture) begin
        res_cnt <= res_cnt + RES_W'(1);
      end
      if (capture) begin
        hold_valid <= 1'b1;
      end else if ((state == ST_FIN) && out_ready) begin
        hold_valid <= 1'b0;
      end
      if (push) begin
        obuf_valid <= 1'b1;
      end else if (m_tready) begin
        obuf_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chan_mode[i]     <= MODE_NONE;
        chan_duration[i] <= '0;
        chan_count[i]    <= '0;
        tick_count[i]    <= '0;
        frame_signed[i]  <= '0;
      end
    end else if (load_we) begin
      chan_mode[cidx]     <= cmd.mode;
      chan_duration[cidx] <= cmd.duration;
      chan_count[cidx]    <= cmd.count;
      tick_count[cidx]    <= '0;
      frame_signed[cidx]  <= load_frame;
    end else if (step_we && active) begin
      tick_count[idx] <= hit ? 8'd0 : tc1;
      if (hit) begin
        frame_signed[idx] <= f_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      hold_chan  <= 4'(idx);
      hold_frame <= shown_frame(f_new);
    end
    if (push) begin
      obuf_chan  <= push_chan;
      obuf_frame <= push_frame;
      obuf_last  <= push_last;
    end
  end

  assign m_tvalid = obuf_valid;
  assign m_tdata  = {5'd0, obuf_frame, obuf_chan};
  assign m_tlast  = obuf_last;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> out_ready)
    else $error("output word overwritten while stalled");

  a_idle_hold_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !hold_valid)
    else $error("held result left over after tick");

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= RES_W'(MAX_RESULTS))
    else $error("result count above limit");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (state == ST_IDLE) && (idx == '0))
    else $error("command taken during walk");

endmodule

/* rtl/core/tile_animation_sequencer.sv */
// Bank of animation channel timers.
// Input stream (s_*): tuser = req_type, 0 = tick all channels, 1 = load one
// channel from tdata (channel, mode, frame_duration, frame_count).
// Output stream (m_*): tdata = out_channel and frame_index, tlast marks the
// final word caused by one input word. A load gives one word; a tick gives one
// word per channel whose frame changed, in channel order, at most 16; a tick
// that changes nothing gives no word.
// The back end takes a load in its idle state; a tick walks the channels one
// channel per cycle while the output is not stalled, through a single step
// unit. A load word passes the command queue, then the output register. A
// two-word command queue lets the input keep accepting while the back end works.
// Reset clears all channels to mode none with zero counters.
// When an output word waits with m_tready low the back end holds its walk,
// the queue fills and s_tready drops; nothing is lost.
module tile_animation_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // channel[3:0], mode[6:4], frame_duration[14:7],
                                 // frame_count[21:15], zero fill
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_channel[3:0], frame_index[10:4], zero fill
  output logic        m_tlast
);
  import tas_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  tas_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tas_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
